/* design/uqkv_pkg.sv */
`default_nettype none

package uqkv_pkg;

  localparam int MaxUrlLength = 4096;
  localparam int KeyChars     = 8;
  localparam int PosW         = 12;
  localparam logic [PosW-1:0] PosCap =
    PosW'(((MaxUrlLength - 1) < 4095) ? (MaxUrlLength - 1) : 4095);

  localparam logic [1:0] RegKeyText   = 2'd0;
  localparam logic [1:0] RegKeyLength = 2'd1;
  localparam logic [1:0] RegValueMode = 2'd2;

  localparam logic [1:0] ModeString   = 2'd0;
  localparam logic [1:0] ModeUnsigned = 2'd1;
  localparam logic [1:0] ModeSigned   = 2'd2;

  localparam logic [1:0] StFound   = 2'd0;
  localparam logic [1:0] StAbsent  = 2'd1;
  localparam logic [1:0] StNoValue = 2'd2;
  localparam logic [1:0] StBad     = 2'd3;

  localparam logic [7:0] CharNul   = 8'h00;
  localparam logic [7:0] CharQuest = 8'h3f;
  localparam logic [7:0] CharHash  = 8'h23;
  localparam logic [7:0] CharAmp   = 8'h26;
  localparam logic [7:0] CharEq    = 8'h3d;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharMinus = 8'h2d;
  localparam logic [7:0] CharLowX  = 8'h78;
  localparam logic [7:0] CharUpX   = 8'h58;

  typedef struct packed {
    logic hex;
    logic signed_limit;
  } uqkv_digit_ctrl_t;

  function automatic logic is_dec(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_dec(c) || ((c >= 8'h61) && (c <= 8'h7a)) ||
           ((c >= 8'h41) && (c <= 8'h5a)) || (c == 8'h5f) || (c == CharMinus);
  endfunction

  // bit 4 set when the character is a hex digit
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (is_dec(c)) begin
      r = {1'b1, c[3:0]};
    end else if (((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46))) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* design/uqkv_if.sv */
`default_nettype none

interface uqkv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] url_byte;

  modport source (output valid, output url_byte, input ready);
  modport sink (input valid, input url_byte, output ready);
endinterface

interface uqkv_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] number_value;
  logic [11:0] value_offset;
  logic [11:0] value_length;
  logic [11:0] path_length;

  modport source (output valid, output status, output number_value, output value_offset,
                  output value_length, output path_length, input ready);
  modport sink (input valid, input status, input number_value, input value_offset,
                input value_length, input path_length, output ready);
endinterface

`default_nettype wire

/* design/uqkv_digit_acc.sv */
`default_nettype none

module uqkv_digit_acc
  import uqkv_pkg::*;
(
  input  wire logic [31:0]      acc_i,
  input  wire logic [3:0]       digit_i,
  input  wire uqkv_digit_ctrl_t ctrl_i,
  output logic [31:0]           acc_o,
  output logic                  ovf_o
);

  logic [35:0] scaled;
  logic [35:0] next;
  logic [35:0] limit;

  always_comb begin
    if (ctrl_i.hex) begin
      scaled = {acc_i, 4'b0000};
    end else begin
      scaled = {1'b0, acc_i, 3'b000} + {3'b000, acc_i, 1'b0};
    end
    next  = scaled + {32'd0, digit_i};
    limit = ctrl_i.signed_limit ? 36'h07fffffff : 36'h0ffffffff;
    ovf_o = next > limit;
    acc_o = next[31:0];
  end

endmodule

`default_nettype wire

/* design/url_query_key_value_parser_unit.sv */
// result: registered; it is valid in the cycle after its terminating zero byte is accepted
// throughput: one url byte per cycle; a byte is taken while the result slot is
// free or being drained, so a held result stalls only the input side
// reset: asynchronous, clears the scanner and the result slot; key_length resets
// to 1, key_text and value_mode to 0
`default_nettype none

module url_query_key_value_parser_unit
  import uqkv_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i,
  uqkv_in_if.sink          url_in,
  uqkv_out_if.source       res_out
);

  typedef enum logic [2:0] {
    PhPath, PhKey, PhSkip, PhVStart, PhVZero, PhVDigit, PhDone
  } phase_e;

  logic [63:0]     key_text_q;
  logic [3:0]      key_len_q;
  logic [1:0]      mode_q;

  phase_e          phase_q, phase_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [PosW-1:0] path_end_q, path_end_d;
  logic [3:0]      key_idx_q, key_idx_d;
  logic            key_match_q, key_match_d;
  logic [31:0]     acc_q, acc_d;
  logic            hex_q, hex_d;
  logic            neg_q, neg_d;
  logic            err_q, err_d;
  logic [PosW-1:0] vstart_q, vstart_d;
  logic [PosW-1:0] vlen_q, vlen_d;
  logic [1:0]      status_q, status_d;

  logic            res_valid_q;
  logic [1:0]      res_status_q;
  logic [31:0]     res_number_q;
  logic [PosW-1:0] res_offset_q;
  logic [PosW-1:0] res_length_q;
  logic [PosW-1:0] res_path_q;

  logic             in_fire;
  logic [7:0]       c;
  logic             numeric;
  logic             key_ok;
  logic [7:0]       key_byte;
  logic [4:0]       hv;
  uqkv_digit_ctrl_t dctrl;
  logic [31:0]      dig_acc;
  logic             dig_ovf;

  assign url_in.ready = !res_valid_q || res_out.ready;
  assign in_fire      = url_in.valid && url_in.ready;
  assign c            = url_in.url_byte;
  assign numeric      = (mode_q == ModeUnsigned) || (mode_q == ModeSigned);
  assign key_ok       = (key_len_q >= 4'd1) && (key_len_q <= 4'(KeyChars));
  assign key_byte     = key_text_q[{key_idx_q[2:0], 3'b000} +: 8];
  assign hv           = hex_val(c);
  assign dctrl.hex          = hex_q;
  assign dctrl.signed_limit = (mode_q == ModeSigned);

  uqkv_digit_acc u_digit (
    .acc_i   (acc_q),
    .digit_i (hv[3:0]),
    .ctrl_i  (dctrl),
    .acc_o   (dig_acc),
    .ovf_o   (dig_ovf)
  );

  always_comb begin
    phase_d     = phase_q;
    pos_d       = (pos_q < PosCap) ? pos_q + 1'b1 : pos_q;
    path_end_d  = path_end_q;
    key_idx_d   = key_idx_q;
    key_match_d = key_match_q;
    acc_d       = acc_q;
    hex_d       = hex_q;
    neg_d       = neg_q;
    err_d       = err_q;
    vstart_d    = vstart_q;
    vlen_d      = vlen_q;
    status_d    = status_q;

    unique case (phase_q)
      PhPath: begin
        if ((c == CharNul) || (c == CharQuest) || (c == CharHash)) begin
          path_end_d = pos_q;
        end
        if (c == CharQuest) begin
          phase_d     = PhKey;
          key_idx_d   = 4'd0;
          key_match_d = 1'b1;
        end else if (c == CharHash) begin
          phase_d = PhDone;
        end
      end
      PhKey: begin
        if (is_word(c)) begin
          if (!(key_match_q && (key_idx_q < key_len_q) && (key_idx_q < 4'(KeyChars)) &&
                (key_byte == c))) begin
            key_match_d = 1'b0;
          end
          if (key_idx_q != 4'd15) begin
            key_idx_d = key_idx_q + 4'd1;
          end
        end else if (key_match_q && key_ok && (key_idx_q == key_len_q)) begin
          if (c == CharEq) begin
            phase_d  = PhVStart;
            vstart_d = (pos_q < PosCap) ? pos_q + 1'b1 : PosCap;
            vlen_d   = '0;
            acc_d    = '0;
            hex_d    = 1'b0;
            neg_d    = 1'b0;
            err_d    = 1'b0;
          end else begin
            status_d = StNoValue;
            phase_d  = PhDone;
          end
        end else if (c == CharAmp) begin
          phase_d     = PhKey;
          key_idx_d   = 4'd0;
          key_match_d = 1'b1;
        end else if (c == CharHash) begin
          phase_d = PhDone;
        end else if (c != CharNul) begin
          phase_d = PhSkip;
        end
      end
      PhSkip: begin
        if (c == CharAmp) begin
          phase_d     = PhKey;
          key_idx_d   = 4'd0;
          key_match_d = 1'b1;
        end else if (c == CharHash) begin
          phase_d = PhDone;
        end
      end
      PhVStart, PhVZero, PhVDigit: begin
        if ((c == CharNul) || (c == CharAmp) || (c == CharHash)) begin
          status_d = err_q ? StBad : StFound;
          phase_d  = PhDone;
        end else begin
          if (vlen_q < PosCap) begin
            vlen_d = vlen_q + 1'b1;
          end
          if (numeric && !err_q) begin
            if (phase_q == PhVStart) begin
              if (c == CharZero) begin
                acc_d   = '0;
                phase_d = PhVZero;
              end else if ((c == CharMinus) && (mode_q == ModeSigned)) begin
                neg_d   = 1'b1;
                phase_d = PhVDigit;
              end else if (is_dec(c)) begin
                acc_d   = {28'd0, c[3:0]};
                phase_d = PhVDigit;
              end else begin
                err_d = 1'b1;
              end
            end else if (phase_q == PhVZero) begin
              if ((c == CharLowX) || (c == CharUpX)) begin
                hex_d   = 1'b1;
                phase_d = PhVDigit;
              end else if (is_dec(c)) begin
                phase_d = PhVDigit;
                if (dig_ovf) begin
                  err_d = 1'b1;
                end else begin
                  acc_d = dig_acc;
                end
              end else begin
                err_d = 1'b1;
              end
            end else begin
              if (hex_q ? hv[4] : is_dec(c)) begin
                if (dig_ovf) begin
                  err_d = 1'b1;
                end else begin
                  acc_d = dig_acc;
                end
              end else begin
                err_d = 1'b1;
              end
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_text_q <= '0;
      key_len_q  <= 4'd1;
      mode_q     <= ModeString;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegKeyText:   key_text_q <= cfg_data_i;
        RegKeyLength: key_len_q  <= cfg_data_i[3:0];
        RegValueMode: mode_q     <= cfg_data_i[1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhPath;
      pos_q        <= '0;
      path_end_q   <= '0;
      key_idx_q    <= '0;
      key_match_q  <= 1'b1;
      acc_q        <= '0;
      hex_q        <= 1'b0;
      neg_q        <= 1'b0;
      err_q        <= 1'b0;
      vstart_q     <= '0;
      vlen_q       <= '0;
      status_q     <= StAbsent;
      res_valid_q  <= 1'b0;
      res_status_q <= '0;
      res_number_q <= '0;
      res_offset_q <= '0;
      res_length_q <= '0;
      res_path_q   <= '0;
    end else begin
      if (in_fire && (c == CharNul)) begin
        res_valid_q <= 1'b1;
      end else if (res_out.ready) begin
        res_valid_q <= 1'b0;
      end
      if (in_fire) begin
        if (c == CharNul) begin
          res_status_q <= status_d;
          res_number_q <= ((status_d == StFound) && numeric) ?
                          (neg_d ? (32'd0 - acc_d) : acc_d) : 32'd0;
          res_offset_q <= vstart_d;
          res_length_q <= vlen_d;
          res_path_q   <= path_end_d;
          phase_q      <= PhPath;
          pos_q        <= '0;
          path_end_q   <= '0;
          key_idx_q    <= '0;
          key_match_q  <= 1'b1;
          acc_q        <= '0;
          hex_q        <= 1'b0;
          neg_q        <= 1'b0;
          err_q        <= 1'b0;
          vstart_q     <= '0;
          vlen_q       <= '0;
          status_q     <= StAbsent;
        end else begin
          phase_q     <= phase_d;
          pos_q       <= pos_d;
          path_end_q  <= path_end_d;
          key_idx_q   <= key_idx_d;
          key_match_q <= key_match_d;
          acc_q       <= acc_d;
          hex_q       <= hex_d;
          neg_q       <= neg_d;
          err_q       <= err_d;
          vstart_q    <= vstart_d;
          vlen_q      <= vlen_d;
          status_q    <= status_d;
        end
      end
    end
  end

  assign res_out.valid        = res_valid_q;
  assign res_out.status       = res_status_q;
  assign res_out.number_value = res_number_q;
  assign res_out.value_offset = res_offset_q;
  assign res_out.value_length = res_length_q;
  assign res_out.path_length  = res_path_q;

endmodule

`default_nettype wire

/* verif/tb_url_query_key_value_parser_unit.sv */
`timescale 1ns / 100ps

module tb_url_query_key_value_parser_unit;
  import uqkv_pkg::*;

  localparam logic [1:0] ModeSpare = 2'd3;
  localparam int unsigned LongHold = 300;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned RandomBytes = 1050;

  typedef enum logic [2:0] {
    ScanPath, ScanKey, ScanSkip, ScanValStart, ScanValZero, ScanValDigit, ScanDone
  } scan_phase_e;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] number;
    logic [11:0] offset;
    logic [11:0] length;
    logic [11:0] path;
  } query_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [63:0] cfg_data_i;

  uqkv_in_if  url_if();
  uqkv_out_if res_if();

  url_query_key_value_parser_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .url_in      (url_if),
    .res_out     (res_if)
  );

  // register mirror
  logic [63:0] cfg_key_text = '0;
  logic [3:0]  cfg_key_len = 4'd1;
  logic [1:0]  cfg_mode = ModeString;

  // scanner mirror
  scan_phase_e scan_phase;
  logic [11:0] scan_pos;
  logic [11:0] path_end;
  logic [11:0] val_start;
  logic [11:0] val_len;
  logic [3:0]  match_idx;
  logic        match_ok;
  logic [31:0] num_acc;
  logic        num_hex;
  logic        num_neg;
  logic        num_err;
  logic [1:0]  query_status;

  query_result_t expected_results[$];
  logic [7:0]    pending_bytes[$];

  logic [7:0]  key_chars[KeyChars];
  int unsigned key_gen_len = 1;
  logic        send_idle;
  logic        recv_idle;
  logic        pressure_armed;
  logic        pressure_done;
  int unsigned send_hold;
  int unsigned recv_hold;

  int unsigned bytes_queued = 0;
  int unsigned bytes_accepted = 0;
  int unsigned urls_seen = 0;
  int unsigned results_checked = 0;
  int unsigned settings_count = 0;
  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;

  string word_set = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_-";
  string path_set = "abcxyz/._-0189%&=+";
  string limit_values[$] = '{
    "4294967295", "4294967296", "2147483647", "2147483648", "-2147483647",
    "-2147483648", "0xffffffff", "0x100000000", "0x7FFFFFFF", "0x80000000",
    "-0x7fffffff", "-0x80000000", "0x", "-", "0", "00", "0x0", "-0", "--1",
    "0x-1", "1x2", "99999999999", "0Xg"
  };

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic dec_char(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic word_member(input logic [7:0] c);
    return dec_char(c) || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
           c == "_" || c == "-";
  endfunction

  function automatic int hex_nibble(input logic [7:0] c);
    if (dec_char(c)) return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  function automatic void clear_scan_state();
    scan_phase = ScanPath;
    scan_pos = '0;
    path_end = '0;
    val_start = '0;
    val_len = '0;
    match_idx = '0;
    match_ok = 1'b1;
    num_acc = '0;
    num_hex = 1'b0;
    num_neg = 1'b0;
    num_err = 1'b0;
    query_status = StAbsent;
  endfunction

  function automatic void open_segment();
    scan_phase = ScanKey;
    match_idx = '0;
    match_ok = 1'b1;
  endfunction

  function automatic void accumulate(input int unsigned base, input int unsigned digit);
    logic [63:0] grown;
    grown = 64'(num_acc) * base + digit;
    if (grown > ((cfg_mode == ModeSigned) ? 64'h7FFF_FFFF : 64'hFFFF_FFFF)) num_err = 1'b1;
    else num_acc = grown[31:0];
  endfunction

  function automatic void take_number_char(input logic [7:0] c);
    int nib;
    nib = hex_nibble(c);
    case (scan_phase)
      ScanValStart: begin
        if (c == CharZero) begin
          num_acc = '0;
          scan_phase = ScanValZero;
        end else if (c == CharMinus && cfg_mode == ModeSigned) begin
          num_neg = 1'b1;
          scan_phase = ScanValDigit;
        end else if (dec_char(c)) begin
          num_acc = nib;
          scan_phase = ScanValDigit;
        end else begin
          num_err = 1'b1;
        end
      end
      ScanValZero: begin
        if (c == CharLowX || c == CharUpX) begin
          num_hex = 1'b1;
          scan_phase = ScanValDigit;
        end else if (dec_char(c)) begin
          accumulate(10, nib);
          scan_phase = ScanValDigit;
        end else begin
          num_err = 1'b1;
        end
      end
      default: begin
        if (num_hex && nib >= 0) accumulate(16, nib);
        else if (!num_hex && dec_char(c)) accumulate(10, nib);
        else num_err = 1'b1;
      end
    endcase
  endfunction

  function automatic void scan_url_byte(input logic [7:0] c);
    logic [11:0]   at;
    logic          hit;
    query_result_t r;
    at = scan_pos;
    if (scan_pos < PosCap) scan_pos = scan_pos + 12'd1;
    case (scan_phase)
      ScanPath: begin
        if (c == CharNul || c == CharQuest || c == CharHash) path_end = at;
        if (c == CharQuest) open_segment();
        else if (c == CharHash) scan_phase = ScanDone;
      end
      ScanKey: begin
        if (word_member(c)) begin
          hit = match_ok && match_idx < cfg_key_len && match_idx < KeyChars;
          if (hit) hit = cfg_key_text[{match_idx[2:0], 3'b000} +: 8] == c;
          if (!hit) match_ok = 1'b0;
          if (match_idx != 4'd15) match_idx = match_idx + 4'd1;
        end else if (match_ok && cfg_key_len >= 1 && cfg_key_len <= KeyChars &&
                     match_idx == cfg_key_len) begin
          if (c == CharEq) begin
            scan_phase = ScanValStart;
            val_start = (at < PosCap) ? at + 12'd1 : PosCap;
            val_len = '0;
            num_acc = '0;
            num_hex = 1'b0;
            num_neg = 1'b0;
            num_err = 1'b0;
          end else begin
            query_status = StNoValue;
            scan_phase = ScanDone;
          end
        end else if (c == CharAmp) begin
          open_segment();
        end else if (c == CharHash) begin
          scan_phase = ScanDone;
        end else if (c != CharNul) begin
          scan_phase = ScanSkip;
        end
      end
      ScanSkip: begin
        if (c == CharAmp) open_segment();
        else if (c == CharHash) scan_phase = ScanDone;
      end
      ScanValStart, ScanValZero, ScanValDigit: begin
        if (c == CharNul || c == CharAmp || c == CharHash) begin
          query_status = num_err ? StBad : StFound;
          scan_phase = ScanDone;
        end else begin
          if (val_len < PosCap) val_len = val_len + 12'd1;
          if ((cfg_mode == ModeUnsigned || cfg_mode == ModeSigned) && !num_err)
            take_number_char(c);
        end
      end
      default: ;
    endcase
    if (c == CharNul) begin
      r.status = query_status;
      if (query_status == StFound && (cfg_mode == ModeUnsigned || cfg_mode == ModeSigned))
        r.number = num_neg ? 32'd0 - num_acc : num_acc;
      else
        r.number = '0;
      r.offset = val_start;
      r.length = val_len;
      r.path = path_end;
      expected_results.push_back(r);
      urls_seen++;
      clear_scan_state();
    end
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= 40) $display("%0t ERROR %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] wanted);
    if (got !== wanted)
      report_error($sformatf("result %0d %s: got %0h want %0h", results_checked, name, got,
                             wanted));
  endtask

  // ---------------------------------------------------------------- driver

  always @(posedge clk_i or negedge rst_ni) begin : url_driver
    if (!rst_ni) begin
      url_if.valid <= 1'b0;
      url_if.url_byte <= '0;
      send_hold <= 0;
      clear_scan_state();
    end else begin
      if (url_if.valid && url_if.ready) begin
        scan_url_byte(url_if.url_byte);
        bytes_accepted++;
      end
      if (!url_if.valid || url_if.ready) begin
        if (send_hold != 0) begin
          send_hold <= send_hold - 1;
          url_if.valid <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
          url_if.valid <= 1'b1;
          url_if.url_byte <= pending_bytes.pop_front();
          send_hold <= send_idle ? $urandom_range(0, 11) : 0;
        end else begin
          url_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    query_result_t want;
    int unsigned   wait_draw;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      recv_hold <= 0;
      pressure_done <= 1'b0;
    end else if (res_if.valid && res_if.ready) begin
      if (expected_results.size() == 0) begin
        report_error($sformatf("result with no url pending, status %0d", res_if.status));
      end else begin
        want = expected_results.pop_front();
        check_field("status", res_if.status, want.status);
        check_field("number_value", res_if.number_value, want.number);
        check_field("value_offset", res_if.value_offset, want.offset);
        check_field("value_length", res_if.value_length, want.length);
        check_field("path_length", res_if.path_length, want.path);
        results_checked++;
      end
      if (pressure_armed && !pressure_done) begin
        pressure_done <= 1'b1;
        recv_hold <= LongHold;
        res_if.ready <= 1'b0;
      end else begin
        wait_draw = recv_idle ? $urandom_range(0, 11) : 0;
        recv_hold <= wait_draw;
        res_if.ready <= (wait_draw == 0);
      end
    end else if (recv_hold != 0) begin
      recv_hold <= recv_hold - 1;
      res_if.ready <= (recv_hold == 1);
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((url_if.valid && url_if.ready) || (res_if.valid && res_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("watchdog: nothing moved for %0d cycles", idle_cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic void push_char(input logic [7:0] c);
    pending_bytes.push_back(c);
    bytes_queued++;
  endfunction

  function automatic void push_str(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i]);
  endfunction

  function automatic void queue_url(input string s);
    push_str(s);
    push_char(CharNul);
  endfunction

  function automatic void push_key(input int n);
    for (int i = 0; i < n; i++) push_char(key_chars[i]);
  endfunction

  function automatic logic [7:0] word_char();
    return word_set[$urandom_range(0, word_set.len() - 1)];
  endfunction

  // any byte that does not end a value
  function automatic logic [7:0] value_junk();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (c == CharAmp || c == CharHash);
    return c;
  endfunction

  function automatic logic [7:0] path_char();
    logic [7:0] c;
    if ($urandom_range(0, 9) != 0) return path_set[$urandom_range(0, path_set.len() - 1)];
    do c = value_junk(); while (c == CharQuest);
    return c;
  endfunction

  function automatic logic [7:0] fragment_char();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return CharQuest;
    if (pick == 1) return CharAmp;
    if (pick == 2) return CharEq;
    if (pick < 6) return key_chars[$urandom_range(0, key_gen_len - 1)];
    return value_junk();
  endfunction

  function automatic logic [63:0] pack_key(input string s, input logic [7:0] fill);
    logic [63:0] v;
    for (int i = 0; i < 8; i++) v[8*i +: 8] = (i < s.len()) ? s[i] : fill;
    return v;
  endfunction

  function automatic void gen_value();
    string hex_digits;
    hex_digits = $sformatf("%0h", $urandom);
    if ($urandom_range(0, 1) != 0) hex_digits = hex_digits.toupper();
    case ($urandom_range(0, 11))
      0: ;
      1: push_str(limit_values[$urandom_range(0, limit_values.size() - 1)]);
      2: push_str($sformatf("%0d", $urandom_range(0, 999)));
      3: push_str($sformatf("%0d", $urandom));
      4: push_str($sformatf("%0d%0d", $urandom_range(1, 9), $urandom));
      5: begin
        push_str($urandom_range(0, 1) ? "0x" : "0X");
        push_str(hex_digits);
      end
      6: push_str($sformatf("-%0d", $urandom_range(0, 1) ? $urandom : $urandom_range(0, 99)));
      7: begin
        push_str("-0x");
        push_str(hex_digits);
      end
      8: begin
        push_str($sformatf("%0d", $urandom_range(0, 9999)));
        push_char(value_junk());
      end
      9: push_str($sformatf("00%0d", $urandom_range(0, 99999)));
      10: repeat ($urandom_range(1, 6)) push_char(value_junk());
      default: push_str($sformatf("0x%0h%08h", $urandom_range(0, 15), $urandom));
    endcase
  endfunction

  function automatic void gen_segment();
    case ($urandom_range(0, 11))
      0, 1, 2, 3, 4: begin
        push_key(key_gen_len);
        push_char(CharEq);
        gen_value();
      end
      5: begin
        push_key(key_gen_len - 1);
        push_char(CharEq);
        gen_value();
      end
      6: begin
        push_key(key_gen_len);
        push_char(word_char());
        push_char(CharEq);
        gen_value();
      end
      7: push_key(key_gen_len);
      8: begin
        push_key(key_gen_len);
        push_char(value_junk());
        gen_value();
      end
      9: begin
        repeat ($urandom_range(1, 4)) push_char(word_char());
        push_char(CharEq);
        gen_value();
      end
      10: ;
      default: repeat ($urandom_range(1, 6)) push_char(value_junk());
    endcase
  endfunction

  function automatic void gen_url();
    int unsigned kind;
    int unsigned segs;
    repeat ($urandom_range(0, 5)) push_char(path_char());
    kind = $urandom_range(0, 19);
    if (kind == 0) begin
      repeat ($urandom_range(1, 12)) push_char(8'($urandom_range(1, 255)));
    end else if (kind > 2) begin
      push_char(CharQuest);
      segs = $urandom_range(1, 4);
      for (int s = 0; s < segs; s++) begin
        if (s != 0) push_char(CharAmp);
        gen_segment();
      end
    end
    if ($urandom_range(0, 5) == 0) begin
      push_char(CharHash);
      repeat ($urandom_range(0, 8)) push_char(fragment_char());
    end
    push_char(CharNul);
  endfunction

  task automatic set_query(input logic [63:0] text, input logic [3:0] len,
                           input logic [1:0] mode, input logic allow_idle);
    logic [63:0] noise_bits;
    noise_bits = {$urandom, $urandom};
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= RegKeyText;
    cfg_data_i <= text;
    @(posedge clk_i);
    cfg_index_i <= RegKeyLength;
    cfg_data_i <= {noise_bits[63:4], len};
    @(posedge clk_i);
    cfg_index_i <= RegValueMode;
    cfg_data_i <= {noise_bits[63:2], mode};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    send_idle <= allow_idle && $urandom_range(0, 3) != 0;
    recv_idle <= allow_idle && $urandom_range(0, 3) != 0;
    cfg_key_text = text;
    cfg_key_len = len;
    cfg_mode = mode;
    for (int i = 0; i < KeyChars; i++) key_chars[i] = text[8*i +: 8];
    key_gen_len = (len >= 1 && len <= KeyChars) ? len : $urandom_range(1, KeyChars);
    settings_count++;
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_bytes.size() != 0 || url_if.valid || expected_results.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin : stimulus
    logic [63:0] text;
    logic [3:0]  len;
    int unsigned phase;
    int unsigned random_start;
    int unsigned phase_start;
    int unsigned budget;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_index_i <= RegKeyText;
    cfg_data_i <= '0;
    send_idle <= 1'b1;
    recv_idle <= 1'b1;
    pressure_armed <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // string spans, key matching rules, fragment handling
    set_query(pack_key("id", 8'h00), 4'd2, ModeString, 1'b1);
    queue_url("");
    queue_url("/index.html");
    queue_url("/p?id=abc&x=1");
    queue_url("/p?idx=1&id=zz");
    queue_url("/p?i=1");
    queue_url("/p#top?id=1");
    queue_url("/p?q=1#x&id=2");
    queue_url("/p?id");
    queue_url("/p?id&id=3");
    queue_url("/p?id=1&id=2");
    queue_url("?=5&&id=");
    queue_url("/p?id.x=2&id=ok#frag");
    wait_drained();

    // unsigned limits, hex prefix, empty and malformed numbers
    set_query(pack_key("n", 8'hff), 4'd1, ModeUnsigned, 1'b1);
    queue_url("?n=4294967295");
    queue_url("?n=4294967296");
    queue_url("?n=0xFFFFFFFF");
    queue_url("?n=0x100000000");
    queue_url("?n=0x");
    queue_url("?n=12a");
    queue_url("?n=-5");
    queue_url("?n=007&n=1");
    wait_drained();

    // signed limits with a full-width key
    set_query(pack_key("abcdefgh", 8'h00), 4'd8, ModeSigned, 1'b1);
    queue_url("?abcdefgh=-2147483648");
    queue_url("?abcdefgh=-0x7fffffff");
    queue_url("?abcdefgh=2147483648");
    queue_url("?abcdefgh=-");
    queue_url("?abcdefgh=0X7FFFFFFF");
    wait_drained();

    // key lengths that never match, spare mode
    set_query(pack_key("ab", 8'h00), 4'd0, ModeSpare, 1'b1);
    queue_url("?ab=2");
    queue_url("?=1&ab=2");
    wait_drained();
    set_query('1, 4'd15, ModeSpare, 1'b1);
    queue_url("?ab=2");
    gen_url();
    gen_url();
    wait_drained();
    set_query('0, 4'd9, ModeUnsigned, 1'b1);
    queue_url("?=3&a=1");
    wait_drained();

    phase = 0;
    random_start = bytes_queued;
    while (bytes_queued - random_start < RandomBytes) begin
      len = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(1, 8));
      if ($urandom_range(0, 9) == 0) len = 4'd0;
      for (int i = 0; i < 8; i++)
        text[8*i +: 8] = (i < len) ? word_char() : 8'($urandom);
      @(posedge clk_i);
      pressure_armed <= (phase == 1);
      set_query(text, len, 2'($urandom_range(0, 3)), 1'b1);
      budget = $urandom_range(100, 220);
      phase_start = bytes_queued;
      while (bytes_queued - phase_start < budget) gen_url();
      wait_drained();
      phase++;
    end

    repeat (8) @(posedge clk_i);
    if (expected_results.size() != 0)
      report_error($sformatf("%0d results never arrived", expected_results.size()));
    $display("covered %0d urls in %0d bytes over %0d register settings, long hold %0s",
             urls_seen, bytes_accepted, settings_count, pressure_done ? "hit" : "missed");
    $display("%0d results compared, %0d mismatches", results_checked, error_count);
    if (error_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
